// File: rtl/core/geared_servo_multiturn_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the geared servo multiturn tracker
// Short forms for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GEARED_SERVO_MULTITURN_TRACKER_MACROS_SVH
`define GEARED_SERVO_MULTITURN_TRACKER_MACROS_SVH

// same-cycle implication, held off during reset
`define GSMT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define GSMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gsmt_pkg.sv
// ----------------------------------------------------------------------------
// gsmt_pkg
// Shared constants, codes and stage item types of the multiturn tracker.
// ----------------------------------------------------------------------------
package gsmt_pkg;

  localparam int ENCODER_BITS_DEF    = 13;
  localparam int TURN_COUNT_BITS_DEF = 24;

  localparam int RAW_MAX_BITS  = 16;  // widest encoder the items carry
  localparam int ANGLE_BITS    = 16;  // 65536 units per turn
  localparam int MOTOR_BITS    = 18;  // signed motor angle
  localparam int POS_BITS      = 40;
  localparam int POS_TURN_BITS = POS_BITS - ANGLE_BITS;
  localparam int ALIGN_BITS    = 14;
  localparam int RATIO_BITS    = 17;
  localparam int PROD_BITS     = MOTOR_BITS + RATIO_BITS + 1;
  localparam int STATUS_BITS   = 2;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 17;
  localparam int OUT_TDATA_BITS = 64;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_POS   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_RATIO  = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_ENTER = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_EXIT  = 4'd3;

  localparam logic [ALIGN_BITS-1:0] ALIGN_RESET     = 14'h3FFF;
  localparam logic [RATIO_BITS-1:0] INV_RATIO_RESET = 17'd65536;
  localparam logic [RATIO_BITS-1:0] PROX_IN_RESET   = 17'd655;
  localparam logic [RATIO_BITS-1:0] PROX_OUT_RESET  = 17'd1310;

  localparam logic FUNC_FEEDBACK = 1'b0;
  localparam logic FUNC_TARGET   = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_FEEDBACK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_REJECTED      = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ANTICLOCKWISE = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_CLOCKWISE     = 2'd3;

  typedef struct packed {
    logic                    func;
    logic [RAW_MAX_BITS-1:0] raw;
    logic [POS_BITS-1:0]     target;
    logic                    override;
  } in_item_t;

  typedef struct packed {
    logic                  func;
    logic [MOTOR_BITS-1:0] motor;
    logic [ANGLE_BITS-1:0] gear;
    logic [POS_BITS-1:0]   target;
    logic                  override;
  } align_item_t;

  typedef struct packed {
    logic                  func;
    logic [ANGLE_BITS-1:0] prod_hi;
    logic [ANGLE_BITS-1:0] gear;
    logic [POS_BITS-1:0]   target;
    logic                  override;
  } mult_item_t;

  typedef struct packed {
    logic                  func;
    logic [POS_BITS-1:0]   position;
    logic [ANGLE_BITS-1:0] shaft;
    logic [POS_BITS-1:0]   target;
    logic                  override;
  } turn_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]    position;
    logic [ANGLE_BITS-1:0]  shaft;
    logic                   holding;
    logic [STATUS_BITS-1:0] status;
  } out_item_t;

endpackage

// File: rtl/core/gsmt_align.sv
// ----------------------------------------------------------------------------
// gsmt_align
// Alignment removal, motor wrap detection and gear offset stepping.
// ----------------------------------------------------------------------------
module gsmt_align #(
  parameter int ENCODER_BITS = gsmt_pkg::ENCODER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [gsmt_pkg::ALIGN_BITS-1:0]     zero_pos,
  input  logic [gsmt_pkg::RATIO_BITS-1:0]     inv_ratio,
  input  logic                                align_clear,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gsmt_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gsmt_pkg::align_item_t               out_item
);

  localparam int SHIFT     = gsmt_pkg::ANGLE_BITS - ENCODER_BITS;
  localparam int DIFF_BITS = gsmt_pkg::MOTOR_BITS + 1;
  localparam logic signed [DIFF_BITS-1:0] HALF_POS = DIFF_BITS'(32768);
  localparam logic signed [DIFF_BITS-1:0] HALF_NEG = -DIFF_BITS'(32768);

  logic [ENCODER_BITS-1:0]                captured_align;
  logic                                   align_valid;
  logic signed [gsmt_pkg::MOTOR_BITS-1:0] prev_motor;
  logic [gsmt_pkg::ANGLE_BITS-1:0]        gear_offset;

  logic                                   fire;
  logic                                   feedback;
  logic [ENCODER_BITS-1:0]                raw;
  logic [ENCODER_BITS-1:0]                align_sel;
  logic signed [ENCODER_BITS:0]           enc_diff;
  logic signed [gsmt_pkg::MOTOR_BITS-1:0] motor;
  logic signed [DIFF_BITS-1:0]            dm;
  logic [gsmt_pkg::ANGLE_BITS-1:0]        gear_next;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign feedback = (in_item.func == gsmt_pkg::FUNC_FEEDBACK);
  assign raw      = in_item.raw[ENCODER_BITS-1:0];

  // negative register selects the captured sample, the first one if none yet
  always_comb begin
    if (zero_pos[gsmt_pkg::ALIGN_BITS-1]) begin
      align_sel = align_valid ? captured_align : raw;
    end else begin
      align_sel = ENCODER_BITS'(zero_pos[gsmt_pkg::ALIGN_BITS-2:0]);
    end
  end

  assign enc_diff = $signed({1'b0, raw}) - $signed({1'b0, align_sel});
  assign motor    = gsmt_pkg::MOTOR_BITS'(enc_diff) <<< SHIFT;
  assign dm       = DIFF_BITS'(motor) - DIFF_BITS'(prev_motor);

  always_comb begin
    if (dm < HALF_NEG) begin
      gear_next = gear_offset + inv_ratio[gsmt_pkg::ANGLE_BITS-1:0];
    end else if (dm > HALF_POS) begin
      gear_next = gear_offset - inv_ratio[gsmt_pkg::ANGLE_BITS-1:0];
    end else begin
      gear_next = gear_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      captured_align <= '0;
      align_valid    <= 1'b0;
      prev_motor     <= '0;
      gear_offset    <= '0;
    end else begin
      if (align_clear) begin
        align_valid <= 1'b0;
      end else if (fire && feedback && zero_pos[gsmt_pkg::ALIGN_BITS-1] &&
                   !align_valid) begin
        captured_align <= raw;
        align_valid    <= 1'b1;
      end
      if (fire && feedback) begin
        prev_motor  <= motor;
        gear_offset <= gear_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.func     <= in_item.func;
      out_item.motor    <= motor;
      out_item.gear     <= gear_next;
      out_item.target   <= in_item.target;
      out_item.override <= in_item.override;
    end
  end

endmodule

// File: rtl/core/gsmt_mult.sv
// ----------------------------------------------------------------------------
// gsmt_mult
// Scales the motor angle by the inverse gear ratio.
// ----------------------------------------------------------------------------
module gsmt_mult (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [gsmt_pkg::RATIO_BITS-1:0] inv_ratio,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gsmt_pkg::align_item_t           in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gsmt_pkg::mult_item_t            out_item
);

  logic                                  fire;
  logic signed [gsmt_pkg::PROD_BITS-1:0] prod;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // bits 31:16 are the floored quotient by 65536, already reduced mod 65536
  assign prod = $signed(in_item.motor) * $signed({1'b0, inv_ratio});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.func     <= in_item.func;
      out_item.prod_hi  <= prod[2*gsmt_pkg::ANGLE_BITS-1:gsmt_pkg::ANGLE_BITS];
      out_item.gear     <= in_item.gear;
      out_item.target   <= in_item.target;
      out_item.override <= in_item.override;
    end
  end

endmodule

// File: rtl/core/gsmt_turns.sv
// ----------------------------------------------------------------------------
// gsmt_turns
// Output shaft angle and whole output turn counting.
// ----------------------------------------------------------------------------
module gsmt_turns #(
  parameter int TURN_COUNT_BITS = gsmt_pkg::TURN_COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gsmt_pkg::mult_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gsmt_pkg::turn_item_t out_item
);

  localparam int DIFF_BITS = gsmt_pkg::ANGLE_BITS + 1;
  localparam logic signed [DIFF_BITS-1:0] HALF_POS = DIFF_BITS'(32768);
  localparam logic signed [DIFF_BITS-1:0] HALF_NEG = -DIFF_BITS'(32768);

  logic [gsmt_pkg::ANGLE_BITS-1:0] prev_shaft;
  logic [TURN_COUNT_BITS-1:0]      turn_count;

  logic                            fire;
  logic                            feedback;
  logic [gsmt_pkg::ANGLE_BITS-1:0] shaft_new;
  logic signed [DIFF_BITS-1:0]     ds;
  logic [TURN_COUNT_BITS-1:0]      turn_next;
  logic [TURN_COUNT_BITS-1:0]      sel_turn;
  logic [gsmt_pkg::ANGLE_BITS-1:0] sel_shaft;
  logic [gsmt_pkg::POS_BITS-1:0]   position;

  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;
  assign feedback  = (in_item.func == gsmt_pkg::FUNC_FEEDBACK);
  assign shaft_new = in_item.gear + in_item.prod_hi;
  assign ds        = $signed({1'b0, shaft_new}) - $signed({1'b0, prev_shaft});

  always_comb begin
    if (ds < HALF_NEG) begin
      turn_next = turn_count + TURN_COUNT_BITS'(1);
    end else if (ds > HALF_POS) begin
      turn_next = turn_count - TURN_COUNT_BITS'(1);
    end else begin
      turn_next = turn_count;
    end
  end

  // a target item reports the position left by the last feedback item
  assign sel_turn  = feedback ? turn_next : turn_count;
  assign sel_shaft = feedback ? shaft_new : prev_shaft;
  assign position  = {gsmt_pkg::POS_TURN_BITS'($signed(sel_turn)), sel_shaft};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_shaft <= '0;
      turn_count <= '0;
    end else if (fire && feedback) begin
      prev_shaft <= shaft_new;
      turn_count <= turn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.func     <= in_item.func;
      out_item.position <= position;
      out_item.shaft    <= sel_shaft;
      out_item.target   <= in_item.target;
      out_item.override <= in_item.override;
    end
  end

endmodule

// File: rtl/core/gsmt_hold.sv
// ----------------------------------------------------------------------------
// gsmt_hold
// Hold hysteresis against the target and set-target handling.
// ----------------------------------------------------------------------------
module gsmt_hold (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [gsmt_pkg::RATIO_BITS-1:0] hold_enter,
  input  logic [gsmt_pkg::RATIO_BITS-1:0] hold_exit,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gsmt_pkg::turn_item_t            in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gsmt_pkg::out_item_t             out_item
);

  localparam int DIFF_BITS = gsmt_pkg::POS_BITS + 2;

  logic signed [gsmt_pkg::POS_BITS-1:0] target_pos;
  logic                                 hold_flag;

  logic                                 fire;
  logic                                 feedback;
  logic signed [DIFF_BITS-1:0]          diff;
  logic signed [DIFF_BITS-1:0]          pin;
  logic signed [DIFF_BITS-1:0]          pout;
  logic                                 near;
  logic                                 far;
  logic                                 rejected;
  logic                                 hold_next;
  logic [gsmt_pkg::STATUS_BITS-1:0]     status;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign feedback = (in_item.func == gsmt_pkg::FUNC_FEEDBACK);

  assign diff = DIFF_BITS'(target_pos) - DIFF_BITS'($signed(in_item.position));
  assign pin  = $signed(DIFF_BITS'(hold_enter));
  assign pout = $signed(DIFF_BITS'(hold_exit));

  // distance compared on both sides of zero instead of taking its magnitude
  assign near = (diff < pin) && (diff > -pin);
  assign far  = (diff > pout) || (diff < -pout);

  assign rejected = !hold_flag && !in_item.override;

  always_comb begin
    if (feedback) begin
      hold_next = (hold_flag || near) && !far;
      status    = gsmt_pkg::ST_FEEDBACK;
    end else begin
      hold_next = hold_flag;
      if (rejected) begin
        status = gsmt_pkg::ST_REJECTED;
      end else if ($signed(in_item.target) < target_pos) begin
        status = gsmt_pkg::ST_ANTICLOCKWISE;
      end else begin
        status = gsmt_pkg::ST_CLOCKWISE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pos <= '0;
      hold_flag  <= 1'b1;
    end else if (fire) begin
      hold_flag <= hold_next;
      if (!feedback && !rejected) begin
        target_pos <= $signed(in_item.target);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.position <= in_item.position;
      out_item.shaft    <= in_item.shaft;
      out_item.holding  <= hold_next;
      out_item.status   <= status;
    end
  end

endmodule

// File: rtl/core/geared_servo_multiturn_tracker.sv
// ----------------------------------------------------------------------------
// geared_servo_multiturn_tracker
// Multiturn output shaft tracking of a geared servo from motor encoder items.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the result side is not stalled,
// and returns one result per item, in order. Work runs through an input
// register and four stages (alignment and gear offset, ratio multiply,
// shaft angle and turn count, hold and target), each of which updates its
// own carried state as it takes an item, so items may follow each other in
// every cycle when not stalled; results leave the hold and target register.
// Angles carry 65536 units per output turn. The configuration channel is
// always ready and is meant to be written only while no item is in flight.
module geared_servo_multiturn_tracker #(
  parameter int ENCODER_BITS    = gsmt_pkg::ENCODER_BITS_DEF,
  parameter int TURN_COUNT_BITS = gsmt_pkg::TURN_COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // raw_angle, target, override (from bit 0), zero padded
  input  logic [(ENCODER_BITS + gsmt_pkg::POS_BITS + 8) / 8 * 8 - 1:0] s_axis_tdata,
  // func
  input  logic [0:0]                          s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // position, shaft_angle, holding (from bit 0), zero padded
  output logic [gsmt_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  // status
  output logic [gsmt_pkg::STATUS_BITS-1:0]    m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gsmt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gsmt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int OUT_PAD_BITS  =
    gsmt_pkg::OUT_TDATA_BITS - gsmt_pkg::POS_BITS - gsmt_pkg::ANGLE_BITS - 1;

  logic [gsmt_pkg::ALIGN_BITS-1:0] zero_pos;
  logic [gsmt_pkg::RATIO_BITS-1:0] inv_ratio;
  logic [gsmt_pkg::RATIO_BITS-1:0] hold_enter;
  logic [gsmt_pkg::RATIO_BITS-1:0] hold_exit;
  logic                            cfg_fire;
  logic                            align_clear;

  logic                            in_valid;
  gsmt_pkg::in_item_t              in_item;
  logic                            s_fire;

  logic                            align_ready;
  logic                            align_valid;
  gsmt_pkg::align_item_t           align_item;
  logic                            mult_ready;
  logic                            mult_valid;
  gsmt_pkg::mult_item_t            mult_item;
  logic                            turn_ready;
  logic                            turn_valid;
  gsmt_pkg::turn_item_t            turn_item;
  logic                            hold_ready;
  gsmt_pkg::out_item_t             out_item;

  logic                            shaft_matches;
  logic                            res_holding;
  logic                            res_rejected;
  logic                            res_accepted;
  logic                            sink_free;
  logic                            ovr_taken;

  // configuration registers
  assign cfg_ready   = 1'b1;
  assign cfg_fire    = cfg_valid && cfg_ready;
  assign align_clear = cfg_fire && (cfg_index == gsmt_pkg::CFG_ZERO_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_pos   <= gsmt_pkg::ALIGN_RESET;
      inv_ratio  <= gsmt_pkg::INV_RATIO_RESET;
      hold_enter <= gsmt_pkg::PROX_IN_RESET;
      hold_exit  <= gsmt_pkg::PROX_OUT_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        gsmt_pkg::CFG_ZERO_POS: begin
          zero_pos <= cfg_data[gsmt_pkg::ALIGN_BITS-1:0];
        end
        gsmt_pkg::CFG_INV_RATIO: begin
          inv_ratio <= cfg_data;
        end
        gsmt_pkg::CFG_HOLD_ENTER: begin
          hold_enter <= cfg_data;
        end
        gsmt_pkg::CFG_HOLD_EXIT: begin
          hold_exit <= cfg_data;
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // input register
  assign s_axis_tready = !in_valid || align_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (align_ready) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.func     <= s_axis_tuser[0];
      in_item.raw      <= gsmt_pkg::RAW_MAX_BITS'(s_axis_tdata[ENCODER_BITS-1:0]);
      in_item.target   <= s_axis_tdata[ENCODER_BITS +: gsmt_pkg::POS_BITS];
      in_item.override <= s_axis_tdata[ENCODER_BITS + gsmt_pkg::POS_BITS];
    end
  end

  gsmt_align #(
    .ENCODER_BITS (ENCODER_BITS)
  ) u_align (
    .clk         (clk),
    .rst         (rst),
    .zero_pos    (zero_pos),
    .inv_ratio   (inv_ratio),
    .align_clear (align_clear),
    .in_valid    (in_valid),
    .in_ready    (align_ready),
    .in_item     (in_item),
    .out_valid   (align_valid),
    .out_ready   (mult_ready),
    .out_item    (align_item)
  );

  gsmt_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .inv_ratio (inv_ratio),
    .in_valid  (align_valid),
    .in_ready  (mult_ready),
    .in_item   (align_item),
    .out_valid (mult_valid),
    .out_ready (turn_ready),
    .out_item  (mult_item)
  );

  gsmt_turns #(
    .TURN_COUNT_BITS (TURN_COUNT_BITS)
  ) u_turns (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mult_valid),
    .in_ready  (turn_ready),
    .in_item   (mult_item),
    .out_valid (turn_valid),
    .out_ready (hold_ready),
    .out_item  (turn_item)
  );

  gsmt_hold u_hold (
    .clk        (clk),
    .rst        (rst),
    .hold_enter (hold_enter),
    .hold_exit  (hold_exit),
    .in_valid   (turn_valid),
    .in_ready   (hold_ready),
    .in_item    (turn_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_item   (out_item)
  );

  assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, out_item.holding, out_item.shaft,
                         out_item.position};
  assign m_axis_tuser = out_item.status;

  // views of the ports for the checks below
  assign shaft_matches = m_axis_tdata[gsmt_pkg::POS_BITS +: gsmt_pkg::ANGLE_BITS] ==
                         m_axis_tdata[gsmt_pkg::ANGLE_BITS-1:0];
  assign res_holding   = m_axis_tdata[gsmt_pkg::POS_BITS + gsmt_pkg::ANGLE_BITS];
  assign res_rejected  = m_axis_tvalid && (m_axis_tuser == gsmt_pkg::ST_REJECTED);
  assign res_accepted  = m_axis_tvalid && (m_axis_tuser != gsmt_pkg::ST_REJECTED);
  assign sink_free     = !m_axis_tvalid || m_axis_tready;
  assign ovr_taken     = turn_valid && hold_ready &&
                         (turn_item.func == gsmt_pkg::FUNC_TARGET) && turn_item.override;

  `include "geared_servo_multiturn_tracker_macros.svh"

  `GSMT_ASSERT_NOW(a_shaft_pos, clk, rst, m_axis_tvalid, shaft_matches, "shaft mismatch")
  `GSMT_ASSERT_NOW(a_reject_hold, clk, rst, res_rejected, !res_holding, "held on reject")
  `GSMT_ASSERT_NOW(a_no_stall, clk, rst, sink_free, s_axis_tready, "input stalled")
  `GSMT_ASSERT_NEXT(a_override, clk, rst, ovr_taken, res_accepted, "override refused")

endmodule
